// File: sv/simcc_keypoint_argmax_decoder_macros.svh
// Assertion helpers for the keypoint argmax decoder.
// Define SYNTH to drop every assertion from the build.
`ifndef SIMCC_KEYPOINT_ARGMAX_DECODER_MACROS_SVH
`define SIMCC_KEYPOINT_ARGMAX_DECODER_MACROS_SVH

`ifndef SYNTH
`define SKAD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);
`define SKAD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SKAD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define SKAD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/skad_pkg.sv
`default_nettype none
package skad_pkg;

    // Stream geometry
    localparam int NUM_KEYPOINTS = 133;
    localparam int X_BINS        = 384;
    localparam int Y_BINS        = 512;
    localparam int LOGIT_WIDTH   = 16;

    localparam int BIN_W  = $clog2(X_BINS + Y_BINS);
    localparam int IDX_W  = 9;
    localparam int KP_W   = 8;
    localparam int POS_W  = 10;
    localparam int LAST_BIN = X_BINS + Y_BINS - 1;

    // Stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    // Configuration port
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int HIGH_W     = 5;

    typedef enum logic [1:0] {
        REG_SELECT_LOW  = 2'd0,
        REG_SELECT_MID  = 2'd1,
        REG_SELECT_HIGH = 2'd2,
        REG_NONE        = 2'd3
    } t_reg_index;

    localparam logic [CFG_DATA_W-1:0] SELECT_LOW_RESET  = 64'd131041;
    localparam logic [CFG_DATA_W-1:0] SELECT_MID_RESET  = 64'd44564480;
    localparam logic [HIGH_W-1:0]     SELECT_HIGH_RESET = 5'd0;

    typedef struct packed {
        logic                           last;
        logic signed [LOGIT_WIDTH-1:0]  score;
        logic signed [POS_W-1:0]        y_position;
        logic signed [POS_W-1:0]        x_position;
        logic [KP_W-1:0]                keypoint_number;
    } t_result;

endpackage
`default_nettype wire

// File: sv/simcc_keypoint_argmax_decoder.sv
// The input register holds each accepted logit; from it the running maxima update and,
// on the last y-logit of a selected keypoint, the result enters the two-entry output
// queue, so o_m_tvalid rises in the cycle after the input register loads. One logit
// per cycle is taken while o_s_tready is high; the maxima compare-update is combinational.
// Reset (synchronous, active low) clears counters, queue and valid flags, and loads the
// selection masks with their default values.
`default_nettype none
`include "simcc_keypoint_argmax_decoder_macros.svh"
module simcc_keypoint_argmax_decoder (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Slave stream
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [skad_pkg::S_TDATA_W-1:0]   i_s_tdata,   // [15:0] logit
    input  wire logic                             i_s_tuser,   // [0] restart
    // Master stream
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [7:0] keypoint_number, [17:8] x_position, [27:18] y_position,
    // [43:28] score, [47:44] zero
    output logic [skad_pkg::M_TDATA_W-1:0]        o_m_tdata,
    output logic                                  o_m_tlast,   // last
    // Configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [skad_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [skad_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [skad_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import skad_pkg::*;

    // Configuration registers
    logic [CFG_DATA_W-1:0] r_sel_low;
    logic [CFG_DATA_W-1:0] r_sel_mid;
    logic [HIGH_W-1:0]     r_sel_high;
    t_reg_index            reg_index;
    logic                  cfg_write;

    // Input register
    logic                          r_in_valid;
    logic signed [LOGIT_WIDTH-1:0] r_in_logit;
    logic                          r_in_restart;

    // Running state
    logic signed [LOGIT_WIDTH-1:0] r_bx, n_bx, r_by, n_by;
    logic [IDX_W-1:0]              r_bxi, n_bxi, r_byi, n_byi;
    logic [BIN_W-1:0]              r_bin, n_bin;
    logic [KP_W-1:0]               r_kp, n_kp, r_em, n_em;

    // Result path
    logic [BIN_W-1:0]              eff_bin;
    logic [BIN_W-1:0]              y_bin;
    logic [KP_W-1:0]               eff_kp;
    logic [KP_W-1:0]               eff_em;
    logic [NUM_KEYPOINTS-1:0]      sel_vec;
    logic [NUM_KEYPOINTS-1:0]      above;
    logic                          emit;
    logic                          later_sel;
    logic signed [LOGIT_WIDTH-1:0] score;
    t_result                       result;

    // Output queue
    t_result      r_fifo [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_occ;
    logic         push;
    logic         drain;
    logic         s_accept;

    // Configuration access
    assign pready    = 1'b1;
    assign reg_index = t_reg_index'(paddr[CFG_ADDR_W-1:3]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        case (reg_index)
            REG_SELECT_LOW:  prdata = r_sel_low;
            REG_SELECT_MID:  prdata = r_sel_mid;
            REG_SELECT_HIGH: prdata = {{(CFG_DATA_W-HIGH_W){1'b0}}, r_sel_high};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_low  <= SELECT_LOW_RESET;
            r_sel_mid  <= SELECT_MID_RESET;
            r_sel_high <= SELECT_HIGH_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                REG_SELECT_LOW:  r_sel_low  <= pwdata;
                REG_SELECT_MID:  r_sel_mid  <= pwdata;
                REG_SELECT_HIGH: r_sel_high <= pwdata[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    assign sel_vec = {r_sel_high, r_sel_mid, r_sel_low};

    // Accept while the queue has room for everything already in flight
    assign drain      = o_m_tvalid & i_m_tready;
    assign o_s_tready = ({1'b0, r_occ} + {2'b00, r_in_valid}) <= (3'd1 + {2'b00, drain});
    assign s_accept   = i_s_tvalid & o_s_tready;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_accept;
        end
        if (s_accept) begin
            r_in_logit   <= i_s_tdata[LOGIT_WIDTH-1:0];
            r_in_restart <= i_s_tuser;
        end
    end

    // Restart clears the counters before the logit is taken
    assign eff_bin = r_in_restart ? '0 : r_bin;
    assign eff_kp  = r_in_restart ? '0 : r_kp;
    assign eff_em  = r_in_restart ? '0 : r_em;
    assign y_bin   = eff_bin - BIN_W'(X_BINS);

    // Keypoints after the current one that are still selected
    always_comb begin
        for (int j = 0; j < NUM_KEYPOINTS; j++) begin
            above[j] = KP_W'(j) > eff_kp;
        end
    end
    assign later_sel = |(sel_vec & above);

    // Update running maxima and counters
    always_comb begin
        n_bx  = r_bx;
        n_bxi = r_bxi;
        n_by  = r_by;
        n_byi = r_byi;
        n_bin = r_bin;
        n_kp  = r_kp;
        n_em  = r_em;
        emit  = 1'b0;
        if (r_in_valid) begin
            n_bin = eff_bin;
            n_kp  = eff_kp;
            n_em  = eff_em;
            if (eff_bin < BIN_W'(X_BINS)) begin
                if (eff_bin == '0 || r_in_logit > r_bx) begin
                    n_bx  = r_in_logit;
                    n_bxi = eff_bin[IDX_W-1:0];
                end
                n_bin = eff_bin + 1'b1;
            end else begin
                if (y_bin == '0 || r_in_logit > r_by) begin
                    n_by  = r_in_logit;
                    n_byi = y_bin[IDX_W-1:0];
                end
                if (eff_bin == BIN_W'(LAST_BIN)) begin
                    n_bin = '0;
                    emit  = sel_vec[eff_kp];
                    n_em  = emit ? eff_em + 1'b1 : eff_em;
                    if (eff_kp == KP_W'(NUM_KEYPOINTS - 1)) begin
                        n_kp = '0;
                        n_em = '0;
                    end else begin
                        n_kp = eff_kp + 1'b1;
                    end
                end else begin
                    n_bin = eff_bin + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
            r_kp  <= '0;
            r_em  <= '0;
        end else begin
            r_bin <= n_bin;
            r_kp  <= n_kp;
            r_em  <= n_em;
        end
        r_bx  <= n_bx;
        r_bxi <= n_bxi;
        r_by  <= n_by;
        r_byi <= n_byi;
    end

    // Form the result from the x maximum and the updated y maximum
    assign score = (r_bx < n_by) ? r_bx : n_by;

    always_comb begin
        result.keypoint_number = eff_em;
        result.score           = score;
        result.last            = ~later_sel;
        if (score > 0) begin
            result.x_position = {1'b0, r_bxi};
            result.y_position = {1'b0, n_byi};
        end else begin
            result.x_position = '1;
            result.y_position = '1;
        end
    end

    // Two-entry output queue
    assign push = r_in_valid & emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_occ    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (drain) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_occ <= r_occ + {1'b0, push} - {1'b0, drain};
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= result;
        end
    end

    assign o_m_tvalid = r_occ != '0;
    assign o_m_tlast  = r_fifo[r_rd_ptr].last;
    assign o_m_tdata  = {{(M_TDATA_W - LOGIT_WIDTH - 2*POS_W - KP_W){1'b0}},
                         r_fifo[r_rd_ptr].score,
                         r_fifo[r_rd_ptr].y_position,
                         r_fifo[r_rd_ptr].x_position,
                         r_fifo[r_rd_ptr].keypoint_number};

    // Checks
    `SKAD_ASSERT_ALWAYS(a_queue_room, i_clk, i_rst_n,
        ({1'b0, r_occ} + {2'b00, r_in_valid}) <= 3'd2, "output queue overcommitted")
    `SKAD_ASSERT_ALWAYS(a_bin_range, i_clk, i_rst_n,
        r_bin <= BIN_W'(LAST_BIN), "bin counter out of range")
    `SKAD_ASSERT_ALWAYS(a_kp_range, i_clk, i_rst_n,
        r_kp < KP_W'(NUM_KEYPOINTS), "keypoint counter out of range")
    `SKAD_ASSERT_IMPLIES(a_emit_on_last_bin, i_clk, i_rst_n,
        push, eff_bin == BIN_W'(LAST_BIN) && n_bin == '0, "result off the last y bin")

endmodule
`default_nettype wire
